FILE: rtl/core/sng_pkg.sv
// Shared types, constants and the exp2 gain table for the stereo noise gate.
// No dependencies; every other file refers to it by scoped names.
package sng_pkg;

   localparam int SAMPLE_BITS     = 24;
   localparam int HOLD_BITS       = 18;
   localparam int EXP_TABLE_DEPTH = 256;
   localparam int EXP_IDX_BITS    = $clog2(EXP_TABLE_DEPTH);

   // register and field widths
   localparam int THR_BITS       = 23;
   localparam int DB_BITS        = 23;
   localparam int COEF_BITS      = 24;
   localparam int HOLD_CFG_BITS  = 18;
   localparam int CSR_DATA_BITS  = 24;
   localparam int CSR_INDEX_BITS = 3;

   // internal arithmetic widths
   localparam int GAIN_BITS   = 24;            // signed dB gain, Q8.16
   localparam int DIFF_BITS   = GAIN_BITS + 1;
   localparam int E_BITS      = 22;            // log2 exponent, Q16
   localparam int E_FRAC_BITS = 16;
   localparam int IP_BITS     = E_BITS - E_FRAC_BITS;
   localparam int LIN_BITS    = 31;            // linear gain, Q30
   localparam int LIN_FRAC    = 30;
   localparam int LOG2_SHIFT  = 24;

   // shared digit-serial multiplier
   localparam int DIGIT_BITS   = 8;
   localparam int MUL_A_BITS   = LIN_BITS;
   localparam int MUL_B_BITS   = (SAMPLE_BITS > DB_BITS) ? SAMPLE_BITS : DB_BITS;
   localparam int MUL_DIGITS   = (MUL_B_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int MUL_B_PAD    = MUL_DIGITS * DIGIT_BITS;
   localparam int MUL_P_BITS   = MUL_A_BITS + MUL_B_PAD;
   localparam int MUL_CNT_BITS = $clog2(MUL_DIGITS);

   // reset values of the control registers
   localparam logic [THR_BITS-1:0]      THRESHOLD_RESET = 23'd47173;
   localparam logic [DB_BITS-1:0]       RANGE_RESET     = 23'd3932160;
   localparam logic [COEF_BITS-1:0]     ATTACK_RESET    = 24'd16661112;
   localparam logic [COEF_BITS-1:0]     RELEASE_RESET   = 24'd16775818;
   localparam logic [HOLD_CFG_BITS-1:0] HOLD_RESET      = 18'd9600;
   localparam logic                     STEREO_RESET    = 1'b1;

   localparam logic [DB_BITS-1:0]      RANGE_MAX      = 23'd5242880;
   localparam logic [E_BITS-1:0]       DB_TO_LOG2_Q24 = 22'd2786635;
   localparam logic [COEF_BITS:0]      COEF_ONE       = 25'd1 << COEF_BITS;
   localparam logic [MUL_P_BITS-1:0]   EXP_HALF       = MUL_P_BITS'(1) << (LOG2_SHIFT - 1);
   localparam logic [MUL_P_BITS-1:0]   LIN_HALF       = MUL_P_BITS'(1) << (LIN_FRAC - 1);
   localparam logic [IP_BITS-1:0]      IP_LIMIT       = IP_BITS'(31);

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_THRESHOLD_LEVEL = 3'd0,
      CSR_RANGE_DB        = 3'd1,
      CSR_ATTACK_COEF     = 3'd2,
      CSR_RELEASE_COEF    = 3'd3,
      CSR_HOLD_SAMPLES    = 3'd4,
      CSR_STEREO_MODE     = 3'd5
   } sng_csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_GATE,
      ST_DIFF,
      ST_STEP_MUL,
      ST_STEP_ADD,
      ST_RED,
      ST_EXP_MUL,
      ST_EXP_ROUND,
      ST_GAIN_LOOK,
      ST_GAIN_SHIFT,
      ST_LEFT_MUL,
      ST_LEFT_ROUND,
      ST_RIGHT_MUL,
      ST_FINISH
   } sng_state_type;

   typedef logic [LIN_BITS-1:0] exp_table_type [EXP_TABLE_DEPTH];

   function automatic logic [63:0] isqrt64(input logic [63:0] value);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_w;
      v     = value;
      res   = '0;
      bit_w = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (v >= res + bit_w) begin
            v   = v - (res + bit_w);
            res = (res >> 1) + bit_w;
         end else begin
            res = res >> 1;
         end
         bit_w = bit_w >> 2;
      end
      return res;
   endfunction

   // entry k = 2^-(k/DEPTH) in Q30, built from 2^-(2^-j) factors
   function automatic exp_table_type build_exp_table();
      exp_table_type tab;
      logic [63:0]   fac [16];
      logic [63:0]   f16;
      logic [63:0]   r;
      fac[0] = isqrt64(64'd536870912 << 30);
      for (int j = 1; j < 16; j++) begin
         fac[j] = isqrt64(fac[j-1] << 30);
      end
      for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
         f16 = (64'(k) << 16) / EXP_TABLE_DEPTH;
         r   = 64'd1073741824;
         for (int j = 0; j < 16; j++) begin
            if (f16[15-j]) begin
               r = (r * fac[j] + 64'd536870912) >> 30;
            end
         end
         tab[k] = LIN_BITS'(r);
      end
      return tab;
   endfunction

   localparam exp_table_type EXP_TABLE = build_exp_table();

endpackage

FILE: rtl/core/sng_if.sv
// Valid/ready channel interfaces for the noise gate: stereo frame in, gated frame out.
// Depends on sng_pkg for field widths.
interface sng_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [sng_pkg::SAMPLE_BITS-1:0] left_sample;
   logic signed [sng_pkg::SAMPLE_BITS-1:0] right_sample;

   modport source (output valid, output left_sample, output right_sample, input ready);
   modport sink   (input valid, input left_sample, input right_sample, output ready);
endinterface

interface sng_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [sng_pkg::SAMPLE_BITS-1:0] left_out;
   logic signed [sng_pkg::SAMPLE_BITS-1:0] right_out;
   logic                                  gate_is_open;
   logic [sng_pkg::DB_BITS-1:0]           reduction_db;

   modport source (output valid, output left_out, output right_out, output gate_is_open,
                   output reduction_db, input ready);
   modport sink   (input valid, input left_out, input right_out, input gate_is_open,
                   input reduction_db, output ready);
endinterface

FILE: rtl/core/stereo_noise_gate_hold_smooth_top.sv
// Stereo noise gate with hold and smoothed attack/release, top level.
// Depends on sng_pkg and the channel interfaces in sng_if.sv.
//
//   channel   dir   handshake            payload
//   req_chan  in    valid/ready          left_sample, right_sample
//   rsp_chan  out   valid/ready          left_out, right_out, gate_is_open, reduction_db
//   csr_*     in    csr_write_en only    csr_index, csr_wdata
//
// Items are handled one at a time: a new item is accepted only once the last one has
// left its finish state. The shared 8-bit-digit multiplier makes four passes per item
// (smoothing step, dB to log2, left gain, right gain).
// Reset is synchronous: gain 0 dB, gate closed, hold empty, registers at defaults.
// A finished item waits in the output register; a new item is accepted meanwhile and
// only its last cycle stalls while rsp_chan.ready is low.
module stereo_noise_gate_hold_smooth_top (
   input  logic                                  clock,
   input  logic                                  reset,
   sng_req_if.sink                               req_chan,
   sng_rsp_if.source                             rsp_chan,
   input  logic                                  csr_write_en,
   input  logic [sng_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [sng_pkg::CSR_DATA_BITS-1:0]     csr_wdata
);

   localparam int SB = sng_pkg::SAMPLE_BITS;

   // control registers
   logic [sng_pkg::THR_BITS-1:0]      threshold_ff;
   logic [sng_pkg::DB_BITS-1:0]       range_ff;
   logic [sng_pkg::COEF_BITS-1:0]     attack_ff;
   logic [sng_pkg::COEF_BITS-1:0]     release_ff;
   logic [sng_pkg::HOLD_CFG_BITS-1:0] hold_cfg_ff;
   logic                              stereo_ff;

   // gate state
   sng_pkg::sng_state_type               state_ff, state_in;
   logic signed [sng_pkg::GAIN_BITS-1:0] gain_ff, gain_in;
   logic [sng_pkg::HOLD_BITS-1:0]        hold_ff, hold_in;
   logic                                 open_ff, open_in;

   // per-item working registers
   logic [SB-1:0]                       mag_l_ff, mag_l_in;
   logic [SB-1:0]                       mag_r_ff, mag_r_in;
   logic                                neg_l_ff, neg_l_in;
   logic                                neg_r_ff, neg_r_in;
   logic                                d_neg_ff, d_neg_in;
   logic [sng_pkg::DB_BITS-1:0]         red_ff, red_in;
   logic [sng_pkg::E_BITS-1:0]          e_ff, e_in;
   logic [sng_pkg::LIN_BITS-1:0]        tab_ff, tab_in;
   logic signed [SB-1:0]                left_ff, left_in;

   // digit-serial multiplier
   logic [sng_pkg::MUL_A_BITS-1:0]   mul_a_ff, mul_a_in;
   logic [sng_pkg::MUL_B_PAD-1:0]    mul_b_ff, mul_b_in;
   logic [sng_pkg::MUL_P_BITS-1:0]   mul_acc_ff, mul_acc_in;
   logic [sng_pkg::MUL_CNT_BITS-1:0] mul_cnt_ff, mul_cnt_in;
   logic [sng_pkg::MUL_A_BITS+sng_pkg::DIGIT_BITS-1:0] mul_partial;
   logic [sng_pkg::MUL_P_BITS-1:0]   mul_next;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic signed [SB-1:0]          rsp_left_ff, rsp_right_ff;
   logic                          rsp_open_ff;
   logic [sng_pkg::DB_BITS-1:0]   rsp_red_ff;
   logic                          rsp_load;
   logic                          req_ready;

   // combinational helpers
   logic signed [SB-1:0]                  right_sel;
   logic [SB-1:0]                         side;
   logic [sng_pkg::DB_BITS-1:0]           rng;
   logic signed [sng_pkg::GAIN_BITS-1:0]  target;
   logic signed [sng_pkg::DIFF_BITS-1:0]  diff;
   logic [sng_pkg::DB_BITS-1:0]           abs_diff;
   logic [sng_pkg::COEF_BITS-1:0]         coef_sel;
   logic [sng_pkg::COEF_BITS:0]           coef_gap;
   logic [sng_pkg::DB_BITS-1:0]           step;
   logic [sng_pkg::MUL_P_BITS-1:0]        exp_sum;
   logic [sng_pkg::IP_BITS-1:0]           e_int;
   logic [sng_pkg::LIN_BITS-1:0]          lin_gain;
   sng_pkg::sng_state_type                mul_done_state;

   function automatic logic [SB-1:0] sample_mag(input logic signed [SB-1:0] s);
      logic [SB-1:0] v;
      v = s;
      return s[SB-1] ? (~v + 1'b1) : v;
   endfunction

   function automatic logic signed [SB-1:0] round_apply(
      input logic [sng_pkg::MUL_P_BITS-1:0] prod,
      input logic                           neg
   );
      logic [sng_pkg::MUL_P_BITS-1:0] sum;
      logic [SB-1:0]                  p;
      sum = prod + sng_pkg::LIN_HALF;
      p   = sum[sng_pkg::LIN_FRAC +: SB];
      return neg ? (~p + 1'b1) : p;
   endfunction

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= sng_pkg::THRESHOLD_RESET;
         range_ff     <= sng_pkg::RANGE_RESET;
         attack_ff    <= sng_pkg::ATTACK_RESET;
         release_ff   <= sng_pkg::RELEASE_RESET;
         hold_cfg_ff  <= sng_pkg::HOLD_RESET;
         stereo_ff    <= sng_pkg::STEREO_RESET;
      end else if (csr_write_en) begin
         unique case (sng_pkg::sng_csr_index_type'(csr_index))
            sng_pkg::CSR_THRESHOLD_LEVEL: threshold_ff <= csr_wdata[sng_pkg::THR_BITS-1:0];
            sng_pkg::CSR_RANGE_DB:        range_ff     <= csr_wdata[sng_pkg::DB_BITS-1:0];
            sng_pkg::CSR_ATTACK_COEF:     attack_ff    <= csr_wdata[sng_pkg::COEF_BITS-1:0];
            sng_pkg::CSR_RELEASE_COEF:    release_ff   <= csr_wdata[sng_pkg::COEF_BITS-1:0];
            sng_pkg::CSR_HOLD_SAMPLES:    hold_cfg_ff  <= csr_wdata[sng_pkg::HOLD_CFG_BITS-1:0];
            sng_pkg::CSR_STEREO_MODE:     stereo_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // datapath helpers
   assign right_sel = stereo_ff ? req_chan.right_sample : req_chan.left_sample;
   assign side      = (mag_l_ff > mag_r_ff) ? mag_l_ff : mag_r_ff;
   assign rng       = (range_ff > sng_pkg::RANGE_MAX) ? sng_pkg::RANGE_MAX : range_ff;
   assign target    = open_ff ? '0 : -$signed(sng_pkg::GAIN_BITS'(rng));
   assign diff      = sng_pkg::DIFF_BITS'(target) - sng_pkg::DIFF_BITS'(gain_ff);
   assign abs_diff  = sng_pkg::DB_BITS'(diff[sng_pkg::DIFF_BITS-1] ? -diff : diff);
   assign coef_sel  = (target > gain_ff) ? attack_ff : release_ff;
   assign coef_gap  = sng_pkg::COEF_ONE - {1'b0, coef_sel};

   // round the smoothing step up
   assign step = mul_acc_ff[sng_pkg::COEF_BITS +: sng_pkg::DB_BITS]
               + sng_pkg::DB_BITS'(|mul_acc_ff[sng_pkg::COEF_BITS-1:0]);

   assign exp_sum  = mul_acc_ff + sng_pkg::EXP_HALF;
   assign e_int    = e_ff[sng_pkg::E_BITS-1:sng_pkg::E_FRAC_BITS];
   assign lin_gain = (e_int >= sng_pkg::IP_LIMIT) ? '0 : (tab_ff >> e_int[4:0]);

   // one digit per cycle, most significant digit first
   assign mul_partial = mul_a_ff * mul_b_ff[sng_pkg::MUL_B_PAD-1 -: sng_pkg::DIGIT_BITS];
   assign mul_next    = (mul_acc_ff << sng_pkg::DIGIT_BITS)
                      + sng_pkg::MUL_P_BITS'(mul_partial);

   always_comb begin
      case (state_ff)
         sng_pkg::ST_STEP_MUL: mul_done_state = sng_pkg::ST_STEP_ADD;
         sng_pkg::ST_EXP_MUL:  mul_done_state = sng_pkg::ST_EXP_ROUND;
         sng_pkg::ST_LEFT_MUL: mul_done_state = sng_pkg::ST_LEFT_ROUND;
         default:              mul_done_state = sng_pkg::ST_FINISH;
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      gain_in    = gain_ff;
      hold_in    = hold_ff;
      open_in    = open_ff;
      mag_l_in   = mag_l_ff;
      mag_r_in   = mag_r_ff;
      neg_l_in   = neg_l_ff;
      neg_r_in   = neg_r_ff;
      d_neg_in   = d_neg_ff;
      red_in     = red_ff;
      e_in       = e_ff;
      tab_in     = tab_ff;
      left_in    = left_ff;
      mul_a_in   = mul_a_ff;
      mul_b_in   = mul_b_ff;
      mul_acc_in = mul_acc_ff;
      mul_cnt_in = mul_cnt_ff;
      req_ready  = 1'b0;
      rsp_load   = 1'b0;

      unique case (state_ff)
         sng_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_chan.valid) begin
               mag_l_in = sample_mag(req_chan.left_sample);
               mag_r_in = sample_mag(right_sel);
               neg_l_in = req_chan.left_sample[SB-1];
               neg_r_in = right_sel[SB-1];
               state_in = sng_pkg::ST_GATE;
            end
         end
         sng_pkg::ST_GATE: begin
            if (side > threshold_ff) begin
               open_in = 1'b1;
               hold_in = sng_pkg::HOLD_BITS'(hold_cfg_ff);
            end else if (hold_ff != '0) begin
               hold_in = hold_ff - 1'b1;
            end else begin
               open_in = 1'b0;
            end
            state_in = sng_pkg::ST_DIFF;
         end
         sng_pkg::ST_DIFF: begin
            d_neg_in   = diff[sng_pkg::DIFF_BITS-1];
            mul_a_in   = sng_pkg::MUL_A_BITS'(coef_gap);
            mul_b_in   = sng_pkg::MUL_B_PAD'(abs_diff);
            mul_acc_in = '0;
            mul_cnt_in = sng_pkg::MUL_CNT_BITS'(sng_pkg::MUL_DIGITS - 1);
            state_in   = sng_pkg::ST_STEP_MUL;
         end
         sng_pkg::ST_STEP_MUL, sng_pkg::ST_EXP_MUL, sng_pkg::ST_LEFT_MUL,
         sng_pkg::ST_RIGHT_MUL: begin
            mul_acc_in = mul_next;
            mul_b_in   = mul_b_ff << sng_pkg::DIGIT_BITS;
            mul_cnt_in = mul_cnt_ff - 1'b1;
            if (mul_cnt_ff == '0) begin
               state_in = mul_done_state;
            end
         end
         sng_pkg::ST_STEP_ADD: begin
            if (d_neg_ff) begin
               gain_in = gain_ff - $signed(sng_pkg::GAIN_BITS'(step));
            end else begin
               gain_in = gain_ff + $signed(sng_pkg::GAIN_BITS'(step));
            end
            state_in = sng_pkg::ST_RED;
         end
         sng_pkg::ST_RED: begin
            red_in     = gain_ff[sng_pkg::GAIN_BITS-1] ? sng_pkg::DB_BITS'(-gain_ff) : '0;
            mul_a_in   = sng_pkg::MUL_A_BITS'(sng_pkg::DB_TO_LOG2_Q24);
            mul_b_in   = sng_pkg::MUL_B_PAD'(red_in);
            mul_acc_in = '0;
            mul_cnt_in = sng_pkg::MUL_CNT_BITS'(sng_pkg::MUL_DIGITS - 1);
            state_in   = sng_pkg::ST_EXP_MUL;
         end
         sng_pkg::ST_EXP_ROUND: begin
            e_in     = exp_sum[sng_pkg::LOG2_SHIFT +: sng_pkg::E_BITS];
            state_in = sng_pkg::ST_GAIN_LOOK;
         end
         sng_pkg::ST_GAIN_LOOK: begin
            tab_in   = sng_pkg::EXP_TABLE[e_ff[sng_pkg::E_FRAC_BITS-1 -: sng_pkg::EXP_IDX_BITS]];
            state_in = sng_pkg::ST_GAIN_SHIFT;
         end
         sng_pkg::ST_GAIN_SHIFT: begin
            // linear gain stays in mul_a for both channel passes
            mul_a_in   = lin_gain;
            mul_b_in   = sng_pkg::MUL_B_PAD'(mag_l_ff);
            mul_acc_in = '0;
            mul_cnt_in = sng_pkg::MUL_CNT_BITS'(sng_pkg::MUL_DIGITS - 1);
            state_in   = sng_pkg::ST_LEFT_MUL;
         end
         sng_pkg::ST_LEFT_ROUND: begin
            left_in    = round_apply(mul_acc_ff, neg_l_ff);
            mul_b_in   = sng_pkg::MUL_B_PAD'(mag_r_ff);
            mul_acc_in = '0;
            mul_cnt_in = sng_pkg::MUL_CNT_BITS'(sng_pkg::MUL_DIGITS - 1);
            state_in   = sng_pkg::ST_RIGHT_MUL;
         end
         sng_pkg::ST_FINISH: begin
            // hold until the output register frees up
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_load = 1'b1;
               state_in = sng_pkg::ST_IDLE;
            end
         end
         default: state_in = sng_pkg::ST_IDLE;
      endcase
   end

   assign rsp_valid_in = rsp_load | (rsp_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sng_pkg::ST_IDLE;
         gain_ff      <= '0;
         hold_ff      <= '0;
         open_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gain_ff      <= gain_in;
         hold_ff      <= hold_in;
         open_ff      <= open_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_l_ff   <= mag_l_in;
      mag_r_ff   <= mag_r_in;
      neg_l_ff   <= neg_l_in;
      neg_r_ff   <= neg_r_in;
      d_neg_ff   <= d_neg_in;
      red_ff     <= red_in;
      e_ff       <= e_in;
      tab_ff     <= tab_in;
      left_ff    <= left_in;
      mul_a_ff   <= mul_a_in;
      mul_b_ff   <= mul_b_in;
      mul_acc_ff <= mul_acc_in;
      mul_cnt_ff <= mul_cnt_in;
      if (rsp_load) begin
         rsp_left_ff  <= left_ff;
         rsp_right_ff <= round_apply(mul_acc_ff, neg_r_ff);
         rsp_open_ff  <= open_ff;
         rsp_red_ff   <= red_ff;
      end
   end

   assign req_chan.ready        = req_ready;
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.left_out     = rsp_left_ff;
   assign rsp_chan.right_out    = rsp_right_ff;
   assign rsp_chan.gate_is_open = rsp_open_ff;
   assign rsp_chan.reduction_db = rsp_red_ff;

endmodule

FILE: dv/tb_stereo_noise_gate_hold_smooth_top.sv
// Testbench for the stereo noise gate: directed and random frames are checked against a
// predictor of gate, hold, dB smoothing and exp2 gain, under random idling and stalls.
// Depends on sng_pkg, the channel interfaces in sng_if.sv and the top level.
module tb_stereo_noise_gate_hold_smooth_top;

   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 40;
   localparam int LONG_HOLDOFF  = 400;
   localparam int REPORT_LIMIT  = 10;
   localparam int PHASE_COUNT   = 7;
   localparam int PHASE_ITEMS   = 180;

   localparam int unsigned FULL_SCALE    = 32'd8388608;    // magnitude of the most negative sample
   localparam int unsigned THRESHOLD_TOP = 32'd8388607;
   localparam int unsigned RANGE_TOP     = 32'd8388607;
   localparam int unsigned COEF_TOP      = 32'd16777215;
   localparam int unsigned HOLD_TOP      = 32'd262143;

   localparam longint unsigned RANGE_CEILING = 64'd5242880;  // 80 dB in Q8.16
   localparam longint unsigned DB_TO_LOG2    = 64'd2786635;  // log2(10)/20 in Q24
   localparam longint unsigned COEF_UNITY    = 64'd1 << 24;
   localparam longint unsigned UNITY_Q30     = 64'd1 << 30;
   localparam longint unsigned HALF_Q30      = 64'd1 << 29;

   typedef struct {
      logic signed [23:0] left_out;
      logic signed [23:0] right_out;
      logic               gate_is_open;
      logic [22:0]        reduction_db;
   } gated_frame_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        csr_write_en;
   logic [sng_pkg::CSR_INDEX_BITS-1:0] csr_index;
   logic [sng_pkg::CSR_DATA_BITS-1:0]  csr_wdata;

   sng_req_if req_chan ();
   sng_rsp_if rsp_chan ();

   stereo_noise_gate_hold_smooth_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_chan     (req_chan),
      .rsp_chan     (rsp_chan),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata)
   );

   always #5 clock = ~clock;

   // predictor copy of registers and state
   longint unsigned thr_cfg, range_cfg, attack_cfg, release_cfg, hold_cfg, stereo_cfg;
   longint          gain_db;
   longint unsigned hold_left;
   logic            gate_open;
   longint unsigned gain_table [256];

   gated_frame_type expected_frames [$];
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           burst_left = 1;
   bit           sender_steady = 0;
   bit           long_holdoff_armed = 0;
   int           holdoff_count = 0;
   int           stall_mode = 0;
   int           mode_left = 0;
   int           stall_phase = 0;

   function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned res;
      longint unsigned cand;
      res = 0;
      for (int b = 31; b >= 0; b--) begin
         cand = res | (64'd1 << b);
         if (cand * cand <= v) res = cand;
      end
      return res;
   endfunction

   // entry k holds 2^-(k/256) in Q30, a product of 2^-(2^-j) factors rounded half up
   function automatic void fill_gain_table();
      longint unsigned halving [16];
      longint unsigned frac16;
      longint unsigned acc;
      halving[0] = root_floor(HALF_Q30 << 30);
      for (int j = 1; j < 16; j++) halving[j] = root_floor(halving[j-1] << 30);
      for (int k = 0; k < 256; k++) begin
         frac16 = (longint'(k) << 16) / 256;
         acc    = UNITY_Q30;
         for (int j = 0; j < 16; j++) begin
            if ((frac16 >> (15 - j)) & 64'd1) acc = (acc * halving[j] + HALF_Q30) >> 30;
         end
         gain_table[k] = acc;
      end
   endfunction

   function automatic void reset_predictor();
      thr_cfg     = sng_pkg::THRESHOLD_RESET;
      range_cfg   = sng_pkg::RANGE_RESET;
      attack_cfg  = sng_pkg::ATTACK_RESET;
      release_cfg = sng_pkg::RELEASE_RESET;
      hold_cfg    = sng_pkg::HOLD_RESET;
      stereo_cfg  = sng_pkg::STEREO_RESET;
      gain_db     = 0;
      hold_left   = 0;
      gate_open   = 1'b0;
   endfunction

   function automatic longint unsigned mag_of(logic [23:0] s);
      return s[23] ? (64'd1 << 24) - s : s;
   endfunction

   function automatic logic [23:0] scale_sample(logic [23:0] s, longint unsigned lin);
      longint unsigned p;
      p = (mag_of(s) * lin + HALF_Q30) >> 30;
      return s[23] ? 24'((64'd1 << 24) - p) : 24'(p);
   endfunction

   function automatic gated_frame_type predict_gate(logic [23:0] l_in, logic [23:0] r_in);
      gated_frame_type res;
      logic [23:0]     r;
      longint unsigned side, rng, coef, absd, step, red, e, whole, idx, lin;
      longint          target, diff;
      r    = stereo_cfg ? r_in : l_in;
      side = (mag_of(l_in) > mag_of(r)) ? mag_of(l_in) : mag_of(r);
      rng  = (range_cfg > RANGE_CEILING) ? RANGE_CEILING : range_cfg;
      if (side > thr_cfg) begin
         gate_open = 1'b1;
         hold_left = hold_cfg;
      end else if (hold_left > 0) begin
         hold_left--;
      end else begin
         gate_open = 1'b0;
      end
      target = gate_open ? 0 : -longint'(rng);
      coef   = (target > gain_db) ? attack_cfg : release_cfg;
      diff   = target - gain_db;
      absd   = (diff < 0) ? -diff : diff;
      // round the step up so the gain always lands on the target
      step   = ((COEF_UNITY - coef) * absd + COEF_UNITY - 1) >> 24;
      if (diff < 0) gain_db = gain_db - longint'(step);
      else          gain_db = gain_db + longint'(step);
      red   = (gain_db < 0) ? -gain_db : 0;
      e     = (red * DB_TO_LOG2 + (64'd1 << 23)) >> 24;
      whole = e >> 16;
      idx   = ((e & 64'hFFFF) * 256) >> 16;
      lin   = (whole >= 31) ? 0 : (gain_table[idx] >> whole);
      res.left_out     = scale_sample(l_in, lin);
      res.right_out    = scale_sample(r, lin);
      res.gate_is_open = gate_open;
      res.reduction_db = 23'(red);
      return res;
   endfunction

   function automatic void note_mismatch(string what, longint want, longint got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("mismatch %s at cycle %0d: expected %0d, got %0d", what, cycle_count, want, got);
   endfunction

   // compare each item that leaves the block with the oldest prediction
   always @(posedge clock) begin : check_results
      gated_frame_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_frames.size() == 0) begin
            note_mismatch("unexpected item", 0, 1);
         end else begin
            want = expected_frames.pop_front();
            if (rsp_chan.left_out !== want.left_out)
               note_mismatch("left_out", want.left_out, rsp_chan.left_out);
            if (rsp_chan.right_out !== want.right_out)
               note_mismatch("right_out", want.right_out, rsp_chan.right_out);
            if (rsp_chan.gate_is_open !== want.gate_is_open)
               note_mismatch("gate_is_open", want.gate_is_open, rsp_chan.gate_is_open);
            if (rsp_chan.reduction_db !== want.reduction_db)
               note_mismatch("reduction_db", want.reduction_db, rsp_chan.reduction_db);
         end
      end
   end

   // receiver: stall pattern that changes at random intervals, plus a long hold-off
   always @(posedge clock) begin : drive_rsp_ready
      if (long_holdoff_armed) begin
         long_holdoff_armed = 0;
         holdoff_count      = LONG_HOLDOFF;
      end
      if (holdoff_count > 0) begin
         holdoff_count--;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            mode_left  = $urandom_range(40, 250);
         end else begin
            mode_left--;
         end
         stall_phase = (stall_phase + 1) % 5;
         case (stall_mode)
            0:       rsp_chan.ready <= 1'b1;
            1:       rsp_chan.ready <= ($urandom_range(0, 9) < 7);
            2:       rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            default: rsp_chan.ready <= (stall_phase == 0);
         endcase
      end
   end

   always @(posedge clock) begin : watchdog
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_frame(input logic [23:0] l, input logic [23:0] r);
      req_chan.valid        <= 1'b1;
      req_chan.left_sample  <= l;
      req_chan.right_sample <= r;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      expected_frames.push_back(predict_gate(l, r));
   endtask

   // end a burst now and then with a gap of random length
   task automatic pace_sender();
      int gap;
      if (sender_steady) return;
      burst_left--;
      if (burst_left > 0) return;
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 6);
      req_chan.valid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (expected_frames.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_register(input sng_pkg::sng_csr_index_type which, input int unsigned value);
      csr_write_en <= 1'b1;
      csr_index    <= which;
      csr_wdata    <= value[23:0];
      case (which)
         sng_pkg::CSR_THRESHOLD_LEVEL: thr_cfg     = value & 32'h7FFFFF;
         sng_pkg::CSR_RANGE_DB:        range_cfg   = value & 32'h7FFFFF;
         sng_pkg::CSR_ATTACK_COEF:     attack_cfg  = value & 32'hFFFFFF;
         sng_pkg::CSR_RELEASE_COEF:    release_cfg = value & 32'hFFFFFF;
         sng_pkg::CSR_HOLD_SAMPLES:    hold_cfg    = value & 32'h3FFFF;
         sng_pkg::CSR_STEREO_MODE:     stereo_cfg  = value & 32'h1;
         default: ;
      endcase
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_all_registers(input int unsigned thr, input int unsigned rng,
                                    input int unsigned att, input int unsigned rel,
                                    input int unsigned hold, input int unsigned stereo);
      set_register(sng_pkg::CSR_THRESHOLD_LEVEL, thr);
      set_register(sng_pkg::CSR_RANGE_DB, rng);
      set_register(sng_pkg::CSR_ATTACK_COEF, att);
      set_register(sng_pkg::CSR_RELEASE_COEF, rel);
      set_register(sng_pkg::CSR_HOLD_SAMPLES, hold);
      set_register(sng_pkg::CSR_STEREO_MODE, stereo);
   endtask

   function automatic logic [23:0] sample_with_mag(int unsigned lo, int unsigned hi);
      int unsigned m;
      m = $urandom_range(hi, lo);
      if (m == FULL_SCALE) return 24'h800000;
      if (m != 0 && $urandom_range(0, 1) == 1) return 24'(-longint'(m));
      return 24'(m);
   endfunction

   function automatic logic [23:0] loud_sample();
      int unsigned lo;
      lo = (thr_cfg >= FULL_SCALE) ? FULL_SCALE : int'(thr_cfg) + 1;
      return sample_with_mag(lo, FULL_SCALE);
   endfunction

   function automatic logic [23:0] quiet_sample();
      return sample_with_mag(0, int'(thr_cfg));
   endfunction

   function automatic logic [23:0] any_sample();
      return 24'($urandom());
   endfunction

   task automatic test_default_settings();
      send_frame(24'sd0, 24'sd0);
      send_frame(24'sh7FFFFF, 24'sh800000);
   endtask

   task automatic test_signal_extremes();
      drain_results();
      // top threshold, range beyond 80 dB, instant smoothing, no hold
      set_all_registers(THRESHOLD_TOP, RANGE_TOP, 0, 0, 0, 1);
      send_frame(24'sh7FFFFF, 24'sh7FFFFF);    // level equal to threshold stays closed
      send_frame(24'sh800000, 24'sd0);         // full scale negative opens
      send_frame(24'sd0, 24'sh800000);
      send_frame(24'sd1, -24'sd1);
      send_frame(-24'sd1, 24'sh7FFFFF);
      drain_results();
      // slowest coefficients still move the gain one step per item
      set_all_registers(100, 5242880, COEF_TOP, COEF_TOP, 0, 1);
      send_frame(24'sd100, -24'sd100);
      send_frame(24'sd100, 24'sd99);
      send_frame(-24'sd101, 24'sd0);
      send_frame(24'sd0, 24'sd101);
   endtask

   task automatic test_mono_copy();
      drain_results();
      set_all_registers(1000, 2000000, 24'h800000, 24'h800000, 0, 0);
      send_frame(24'sd5000, 24'sh800000);
      send_frame(24'sh800000, 24'sd12);
      send_frame(24'sd0, 24'sh7FFFFF);         // loud right input is ignored
      send_frame(-24'sd300, 24'sd300);
   endtask

   task automatic test_hold_countdown();
      drain_results();
      set_register(sng_pkg::CSR_STEREO_MODE, 1);
      set_register(sng_pkg::CSR_HOLD_SAMPLES, 3);
      send_frame(24'sd2000, 24'sd0);
      repeat (5) send_frame(24'sd10, -24'sd10);
      send_frame(24'sd0, -24'sd1001);
   endtask

   task automatic test_output_backpressure();
      drain_results();
      sender_steady      = 1;
      long_holdoff_armed = 1;
      repeat (40) send_frame(any_sample(), any_sample());
      sender_steady = 0;
   endtask

   function automatic int unsigned random_coef();
      case ($urandom_range(0, 3))
         0:       return $urandom_range(0, COEF_TOP);
         1:       return $urandom_range(16000000, COEF_TOP);
         2:       return COEF_TOP - $urandom_range(0, 255);
         default: return $urandom_range(0, 4000000);
      endcase
   endfunction

   task automatic configure_phase(input int phase);
      int unsigned thr;
      int unsigned hold;
      drain_results();
      if (phase == 0) begin
         set_all_registers(0, 0, 0, 0, 0, 0);
      end else if (phase == PHASE_COUNT - 1) begin
         set_all_registers(THRESHOLD_TOP, RANGE_TOP, COEF_TOP, COEF_TOP, HOLD_TOP, 1);
      end else begin
         case ($urandom_range(0, 2))
            0:       thr = $urandom_range(0, 2000);
            1:       thr = $urandom_range(0, 300000);
            default: thr = $urandom_range(0, THRESHOLD_TOP);
         endcase
         hold = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) : $urandom_range(0, 40);
         set_all_registers(thr, $urandom_range(0, RANGE_TOP), random_coef(), random_coef(),
                           hold, $urandom_range(0, 1));
      end
   endtask

   // loud and quiet stretches drive the gate through open, hold and close; some noise
   task automatic test_random_phases();
      int          sent;
      int          kind;
      int          len;
      logic [23:0] l;
      logic [23:0] r;
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         configure_phase(phase);
         sender_steady = (phase % 3 == 2);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            kind = $urandom_range(0, 9);
            len  = $urandom_range(1, 48);
            for (int i = 0; i < len && sent < PHASE_ITEMS; i++) begin
               if (kind < 4) begin
                  if (stereo_cfg == 0 || $urandom_range(0, 1) == 0) begin
                     l = loud_sample();
                     r = any_sample();
                  end else begin
                     l = any_sample();
                     r = loud_sample();
                  end
               end else if (kind < 8) begin
                  l = quiet_sample();
                  r = quiet_sample();
               end else begin
                  l = any_sample();
                  r = any_sample();
               end
               send_frame(l, r);
               pace_sender();
               sent++;
            end
         end
         sender_steady = 0;
      end
   endtask

   initial begin : run_tests
      int waited;
      fill_gain_table();
      reset_predictor();
      reset                 = 1'b1;
      csr_write_en          = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      req_chan.valid        = 1'b0;
      req_chan.left_sample  = '0;
      req_chan.right_sample = '0;
      rsp_chan.ready        = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_default_settings();
      test_signal_extremes();
      test_mono_copy();
      test_hold_countdown();
      test_output_backpressure();
      test_random_phases();

      req_chan.valid <= 1'b0;
      waited = 0;
      while (expected_frames.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_frames.size() != 0) begin
         $display("%0d items never came out", expected_frames.size());
         mismatch_count += expected_frames.size();
      end
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
